// File: sv/single_wire_backlight_transmitter_assert.svh
// assertion macros for the single-wire backlight transmitter
// expects clk and arst_n in the scope of each use
`ifndef SINGLE_WIRE_BACKLIGHT_TRANSMITTER_ASSERT_SVH
`define SINGLE_WIRE_BACKLIGHT_TRANSMITTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SWBL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SWBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/swbl_pkg.sv
// shared types, constants and helpers of the single-wire backlight transmitter
// no dependencies
`timescale 1ns / 1ps

package swbl_pkg;

	localparam int TIMER_WIDTH  = 16;
	localparam int MAX_ATTEMPTS = 3;
	localparam int ATT_W        = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 3;

	typedef logic [TIMER_WIDTH-1:0] timer_t;

	// phase codes
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_START     = 3'd1;
	localparam logic [2:0] PH_BIT_LOW   = 3'd2;
	localparam logic [2:0] PH_BIT_HIGH  = 3'd3;
	localparam logic [2:0] PH_EOS       = 3'd4;
	localparam logic [2:0] PH_ACK_PULSE = 3'd5;
	localparam logic [2:0] PH_ACK_WAIT  = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RFA_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_TICKS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EOS_TICKS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_PULSE_TICKS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT     = 3'd7;

	// frame bit positions
	localparam logic [3:0] BIT_FIRST     = 4'd15;
	localparam logic [3:0] BIT_ADDR_LAST = 4'd8;
	localparam logic [3:0] BIT_DATA_TOP  = 4'd7;
	localparam logic [3:0] BIT_LAST      = 4'd0;
	localparam int         BIT_RFA       = 7;

	// register reset values
	localparam logic [7:0] RST_DEVICE_ADDRESS = 8'd88;
	localparam timer_t RST_START_TICKS       = 16'd45;
	localparam timer_t RST_EOS_TICKS         = 16'd35;
	localparam timer_t RST_SHORT_TICKS       = 16'd35;
	localparam timer_t RST_LONG_TICKS        = 16'd100;
	localparam timer_t RST_ACK_PULSE_TICKS   = 16'd35;
	localparam timer_t RST_ACK_TIMEOUT       = 16'd10000;

	typedef struct packed {
		logic       rfa_enable;
		logic [7:0] device_address;
		timer_t     start_ticks;
		timer_t     eos_ticks;
		timer_t     short_ticks;
		timer_t     long_ticks;
		timer_t     ack_pulse_ticks;
		timer_t     ack_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       mode;
		logic [4:0] brightness;
		logic       line_level;
	} tick_t;

	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic status;
	} result_t;

	// a zero length counts as one tick
	function automatic timer_t clamp_len(input timer_t v);
		clamp_len = (v == '0) ? timer_t'(1) : v;
	endfunction

endpackage

// File: sv/swbl_chan_if.sv
// handshake channels of the single-wire backlight transmitter: tick items in, result items out
// depends on swbl_pkg
`timescale 1ns / 1ps

interface swbl_tick_if;
	import swbl_pkg::*;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [4:0] brightness;
	logic       line_level;

	modport source (output valid, mode, brightness, line_level, input ready);
	modport sink (input valid, mode, brightness, line_level, output ready);
endinterface

interface swbl_result_if;
	logic valid;
	logic ready;
	logic drive_low;
	logic busy_res;
	logic done_res;
	logic status;

	modport source (output valid, drive_low, busy_res, done_res, status, input ready);
	modport sink (input valid, drive_low, busy_res, done_res, status, output ready);
endinterface

// File: sv/swbl_core.sv
// transaction sequencer: phase, phase timer, bit index, frame word and attempt count
// depends on swbl_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "single_wire_backlight_transmitter_assert.svh"

module swbl_core
	import swbl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  tick_t   tick,
	input  cfg_t    cfg,
	output result_t res
);

	logic [2:0]       phase_q;
	timer_t           timer_q;
	logic [3:0]       bit_idx_q;
	logic [15:0]      frame_q;
	logic [ATT_W-1:0] attempt_q;

	logic [2:0]       ph_a, ph_n;
	timer_t           tmr_a, tmr_n;
	logic [3:0]       bi_a, bi_n, bi_dec;
	logic [15:0]      fw_a;
	logic [ATT_W-1:0] att_a, att_n;
	logic [ATT_W:0]   att_inc;
	logic             bit_now, bit_next;

	always_comb begin
		ph_a  = phase_q;
		tmr_a = timer_q;
		bi_a  = bit_idx_q;
		fw_a  = frame_q;
		att_a = attempt_q;

		// an unknown phase code counts as idle; a request starts the start gap at once
		if (!(phase_q >= PH_START && phase_q <= PH_ACK_WAIT)) begin
			ph_a = PH_IDLE;
			if (tick.mode) begin
				fw_a  = {cfg.device_address, cfg.rfa_enable, 2'b00, tick.brightness};
				att_a = '0;
				bi_a  = BIT_FIRST;
				ph_a  = PH_START;
				tmr_a = clamp_len(cfg.start_ticks);
			end
		end

		bi_dec   = bi_a - 4'd1;
		bit_now  = fw_a[bi_a];
		bit_next = fw_a[bi_dec];
		att_inc  = {1'b0, att_a} + (ATT_W+1)'(1);

		ph_n  = ph_a;
		tmr_n = tmr_a;
		bi_n  = bi_a;
		att_n = att_a;
		res   = '0;

		if (ph_a != PH_IDLE) begin
			res.busy_res  = 1'b1;
			res.drive_low = (ph_a == PH_BIT_LOW) || (ph_a == PH_EOS) ||
				(ph_a == PH_ACK_PULSE);
			if (ph_a == PH_ACK_WAIT && !tick.line_level) begin
				// device acknowledged
				res.done_res = 1'b1;
				ph_n         = PH_IDLE;
				tmr_n        = '0;
			end else begin
				tmr_n = (tmr_a != '0) ? tmr_a - timer_t'(1) : '0;
				if (tmr_n == '0) begin
					unique case (ph_a)
						PH_START: begin
							ph_n  = PH_BIT_LOW;
							tmr_n = clamp_len(bit_now ? cfg.short_ticks : cfg.long_ticks);
						end
						PH_BIT_LOW: begin
							ph_n  = PH_BIT_HIGH;
							tmr_n = clamp_len(bit_now ? cfg.long_ticks : cfg.short_ticks);
						end
						PH_BIT_HIGH: begin
							if (bi_a == BIT_ADDR_LAST) begin
								ph_n  = PH_EOS;
								tmr_n = clamp_len(cfg.eos_ticks);
							end else if (bi_a == BIT_LAST) begin
								if (fw_a[BIT_RFA]) begin
									ph_n  = PH_ACK_PULSE;
									tmr_n = clamp_len(cfg.ack_pulse_ticks);
								end else begin
									res.done_res = 1'b1;
									ph_n         = PH_IDLE;
								end
							end else begin
								bi_n  = bi_dec;
								ph_n  = PH_BIT_LOW;
								tmr_n = clamp_len(bit_next ? cfg.short_ticks : cfg.long_ticks);
							end
						end
						PH_EOS: begin
							bi_n  = BIT_DATA_TOP;
							ph_n  = PH_START;
							tmr_n = clamp_len(cfg.start_ticks);
						end
						PH_ACK_PULSE: begin
							ph_n  = PH_ACK_WAIT;
							tmr_n = clamp_len(cfg.ack_timeout_ticks);
						end
						PH_ACK_WAIT: begin
							// timeout: retry or give up
							if (att_inc >= (ATT_W+1)'(MAX_ATTEMPTS)) begin
								res.done_res = 1'b1;
								res.status   = 1'b1;
								ph_n         = PH_IDLE;
							end else begin
								att_n = att_inc[ATT_W-1:0];
								bi_n  = BIT_FIRST;
								ph_n  = PH_START;
								tmr_n = clamp_len(cfg.start_ticks);
							end
						end
						default: begin
							ph_n = PH_IDLE;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			bit_idx_q <= '0;
			frame_q   <= '0;
			attempt_q <= '0;
		end else if (step_en) begin
			phase_q   <= ph_n;
			timer_q   <= tmr_n;
			bit_idx_q <= bi_n;
			frame_q   <= fw_a;
			attempt_q <= att_n;
		end
	end

	`SWBL_ASSERT_NEXT(a_hold_without_step, !step_en,
		$stable(phase_q) && $stable(timer_q) && $stable(bit_idx_q), "state moved without a step")
	`SWBL_ASSERT_NEXT(a_idle_after_done, step_en && res.done_res,
		phase_q == PH_IDLE, "phase not idle after a finishing tick")
	`SWBL_ASSERT_NEXT(a_stay_idle, step_en && phase_q == PH_IDLE && !tick.mode,
		phase_q == PH_IDLE, "left idle without a request")
	`SWBL_ASSERT_NOW(a_attempt_range, 1'b1,
		{1'b0, attempt_q} < (ATT_W+1)'(MAX_ATTEMPTS), "attempt count out of range")
	`SWBL_ASSERT_NOW(a_status_with_done, step_en && res.status,
		res.done_res && phase_q == PH_ACK_WAIT, "no-ack status outside a timed-out wait")

endmodule

// File: sv/single_wire_backlight_transmitter.sv
// top level of the single-wire backlight transmitter: config registers, tick register, result register
// depends on swbl_pkg, swbl_chan_if and swbl_core
`timescale 1ns / 1ps

// Single-wire backlight transmitter. Each item on the ticks channel is one timing tick of the
// wire: mode 1 asks for a write (taken only when no transaction is running), brightness is
// latched with it and line_level is the sensed wire. Each tick yields exactly one result item
// carrying drive_low for that tick, busy_res, done_res and status (0 ok, 1 no ack after all
// attempts). A frame is a start gap, the address byte, an end-of-stream low, another start gap
// and the data byte (rfa flag in bit 7, brightness in bits 4..0), msb first; with rfa set an ack
// pulse and a sampled wait follow, retried up to three attempts. Throughput is one item per clock
// cycle unless results stall; a tick register feeds the sequencer logic, whose result lands in the
// output register. The tick register refills whenever the output register is empty or being
// drained; while a result waits unread the tick register still takes one more item and then
// holds ticks.ready low until the result is taken. Config registers are written through
// cfg_we/cfg_index/cfg_data and are read live whenever a phase begins, so write them only while
// idle.

module single_wire_backlight_transmitter
	import swbl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	swbl_tick_if.sink             ticks,
	swbl_result_if.source         results
);

	cfg_t    cfg_q;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;

	result_t res_core;
	logic    out_free;
	logic    advance;

	// output register can load when empty or being taken
	assign out_free    = !valid_s2 || results.ready;
	assign advance     = valid_s1 && out_free;
	assign ticks.ready = !valid_s1 || out_free;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rfa_enable        <= 1'b0;
			cfg_q.device_address    <= RST_DEVICE_ADDRESS;
			cfg_q.start_ticks       <= RST_START_TICKS;
			cfg_q.eos_ticks         <= RST_EOS_TICKS;
			cfg_q.short_ticks       <= RST_SHORT_TICKS;
			cfg_q.long_ticks        <= RST_LONG_TICKS;
			cfg_q.ack_pulse_ticks   <= RST_ACK_PULSE_TICKS;
			cfg_q.ack_timeout_ticks <= RST_ACK_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RFA_ENABLE:      cfg_q.rfa_enable        <= cfg_data[0];
				REG_DEVICE_ADDRESS:  cfg_q.device_address    <= cfg_data[7:0];
				REG_START_TICKS:     cfg_q.start_ticks       <= cfg_data;
				REG_EOS_TICKS:       cfg_q.eos_ticks         <= cfg_data;
				REG_SHORT_TICKS:     cfg_q.short_ticks       <= cfg_data;
				REG_LONG_TICKS:      cfg_q.long_ticks        <= cfg_data;
				REG_ACK_PULSE_TICKS: cfg_q.ack_pulse_ticks   <= cfg_data;
				REG_ACK_TIMEOUT:     cfg_q.ack_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick register: valid bit under reset, payload without reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ticks.ready) begin
			valid_s1 <= ticks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			tick_s1 <= '{mode: ticks.mode, brightness: ticks.brightness,
				line_level: ticks.line_level};
		end
	end

	// sequencer steps once per item leaving the tick register
	swbl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.tick    (tick_s1),
		.cfg     (cfg_q),
		.res     (res_core)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_core;
		end
	end

	assign results.valid     = valid_s2;
	assign results.drive_low = res_s2.drive_low;
	assign results.busy_res  = res_s2.busy_res;
	assign results.done_res  = res_s2.done_res;
	assign results.status    = res_s2.status;

endmodule
